### hdl/prfs_pkg.sv
// ----------------------------------------------------------------------------
// Path recorder flash saver package
// Shared widths, command codes and the front-to-back item type.
// ----------------------------------------------------------------------------
package prfs_pkg;

    localparam int MAX_POINTS_DEF  = 512;
    localparam int POINTS_PER_PAGE = 32;
    localparam int PAGE_BYTES      = POINTS_PER_PAGE * 8;
    localparam int ADDR_W          = 23;
    localparam int POS_W           = 24;
    localparam int THR_W           = 50;

    localparam logic [2:0] CMD_SAMPLE = 3'd0;
    localparam logic [2:0] CMD_ERASE  = 3'd1;
    localparam logic [2:0] CMD_SAVE   = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;
    localparam logic [2:0] CMD_INIT   = 3'd5;

    localparam logic [1:0] CFG_THR   = 2'd0;
    localparam logic [1:0] CFG_BASE  = 2'd1;
    localparam logic [1:0] CFG_SECT  = 2'd2;
    localparam logic [1:0] CFG_MAGIC = 2'd3;

    localparam logic [1:0] FC_NONE  = 2'd0;
    localparam logic [1:0] FC_ERASE = 2'd1;
    localparam logic [1:0] FC_PROG  = 2'd2;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_ERASE = 2'd1,
        OP_SAVE  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SS_HDR   = 3'd0,
        SS_HPOLL = 3'd1,
        SS_PAGE  = 3'd2,
        SS_PPOLL = 3'd3,
        SS_MAGIC = 3'd4,
        SS_MPOLL = 3'd5
    } t_sub;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_EMIT  = 2'd2,
        BK_WORDS = 2'd3
    } t_bk_state;

    // Item handed from the front to the back. Status is taken after the step.
    typedef struct packed {
        logic [1:0]        kind;      // 0 single result, 1 read point, 2 page words
        logic [1:0]        fcmd;
        logic [ADDR_W-1:0] addr;
        logic [8:0]        len;
        logic [31:0]       data;
        logic              op_busy;
        logic              valid;
        logic [9:0]        count;
        logic              taken;
        logic [12:0]       first;     // first point index or read index
        logic [5:0]        chunk;     // points in the page
        logic              in_range;
    } t_item;

    localparam logic [1:0] K_SINGLE = 2'd0;
    localparam logic [1:0] K_READ   = 2'd1;
    localparam logic [1:0] K_PAGE   = 2'd2;

endpackage

### hdl/prfs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/prfs_front.sv
// ----------------------------------------------------------------------------
// Path recorder front end
// Accepts commands, keeps the scalar state and sequencer, writes the point
// store, and passes one item per command to the queue.
// ----------------------------------------------------------------------------
module prfs_front
    import prfs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int IDX_W = $clog2(MAX_POINTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic [POS_W-1:0]   i_pos_x,
    input  logic [POS_W-1:0]   i_pos_y,
    input  logic               i_flash_busy,
    input  logic [8:0]         i_read_index,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output logic               o_we,
    output logic [IDX_W-1:0]   o_waddr,
    output logic [POS_W-1:0]   o_wx,
    output logic [POS_W-1:0]   o_wy,
    output logic               o_item_valid,
    input  logic               i_item_ready,
    output t_item              o_item
);
    localparam int CNT_W = IDX_W + 1;

    logic [THR_W-1:0]  r_thr;
    logic [ADDR_W-1:0] r_base;
    logic [10:0]       r_sect;
    logic [31:0]       r_magic;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_lx, r_ly, n_lx, n_ly;
    t_op               r_op, n_op;
    t_sub              r_sub, n_sub;
    logic [7:0]        r_page, n_page;
    logic              r_valid, n_valid;
    // Two-stage sample path: differences squared, then compare.
    logic              r_sq_pend;
    logic [49:0]       r_sq;
    logic [POS_W-1:0]  r_sx, r_sy;
    logic signed [POS_W:0] dx, dy;
    logic signed [49:0] dxx, dyy;
    logic              acc;
    t_item             it;
    logic              take;

    assign o_ready = i_item_ready && !r_sq_pend;
    assign acc     = i_valid && o_ready;
    assign dx  = $signed({i_pos_x[POS_W-1], i_pos_x}) - $signed({r_lx[POS_W-1], r_lx});
    assign dy  = $signed({i_pos_y[POS_W-1], i_pos_y}) - $signed({r_ly[POS_W-1], r_ly});
    assign dxx = dx * dx;
    assign dyy = dy * dy;

    assign take = r_sq_pend && (r_count < CNT_W'(MAX_POINTS))
                  && ({1'b0, r_sq} >= {1'b0, r_thr});

    always_comb begin
        logic [CNT_W+2:0] first;
        logic [CNT_W+2:0] rem;
        n_count = r_count; n_lx = r_lx; n_ly = r_ly; n_op = r_op; n_sub = r_sub;
        n_page = r_page; n_valid = r_valid;
        it = '0;
        it.kind = K_SINGLE;
        o_item_valid = 1'b0;
        first = {r_page, 5'd0};
        rem = {3'd0, r_count} - first;
        if (r_sq_pend) begin
            o_item_valid = 1'b1;
            if (take) begin
                n_count = r_count + 1'b1;
                n_lx = r_sx; n_ly = r_sy;
            end
            it.taken = take;
        end else if (acc) begin
            case (i_command)
                CMD_SAMPLE: ;
                CMD_ERASE: begin
                    o_item_valid = 1'b1;
                    if (r_op == OP_IDLE) begin n_op = OP_ERASE; n_sub = SS_HDR; end
                end
                CMD_SAVE: begin
                    o_item_valid = 1'b1;
                    if (r_op == OP_IDLE) begin
                        n_op = OP_SAVE; n_sub = SS_HDR; n_page = '0;
                    end
                end
                CMD_TICK: begin
                    o_item_valid = 1'b1;
                    if (r_op == OP_ERASE) begin
                        if (r_sub == SS_HDR) begin
                            it.fcmd = FC_ERASE; it.addr = ADDR_W'(r_sect);
                            n_sub = SS_HPOLL;
                        end else if (!i_flash_busy) begin
                            n_op = OP_IDLE; n_sub = SS_HDR;
                        end
                    end else if (r_op == OP_SAVE) begin
                        case (r_sub)
                            SS_HDR: begin
                                it.fcmd = FC_PROG; it.addr = r_base + ADDR_W'(4);
                                it.len = 9'd4; it.data = 32'(r_count);
                                n_sub = SS_HPOLL;
                            end
                            SS_HPOLL: if (!i_flash_busy) begin
                                n_sub = SS_PAGE; n_page = '0;
                            end
                            SS_PAGE: begin
                                n_sub = SS_PPOLL;
                                // A page with no points gives a plain status result.
                                if ({3'd0, r_count} > first) begin
                                    it.fcmd = FC_PROG;
                                    it.addr = r_base + ADDR_W'(8)
                                              + ADDR_W'({r_page, 8'd0});
                                    it.kind = K_PAGE;
                                    it.first = 13'(first);
                                    it.chunk = (rem > 32) ? 6'd32 : 6'(rem);
                                    it.len = {it.chunk, 3'd0};
                                end
                            end
                            SS_PPOLL: if (!i_flash_busy) begin
                                n_page = r_page + 1'b1;
                                n_sub = ({3'd0, r_count} > (first + 32)) ? SS_PAGE
                                                                        : SS_MAGIC;
                            end
                            SS_MAGIC: begin
                                it.fcmd = FC_PROG; it.addr = r_base; it.len = 9'd4;
                                it.data = r_magic; n_sub = SS_MPOLL;
                            end
                            default: if (!i_flash_busy) begin
                                n_op = OP_IDLE; n_sub = SS_HDR; n_valid = 1'b1;
                            end
                        endcase
                    end
                end
                CMD_READ: begin
                    o_item_valid = 1'b1;
                    it.kind = K_READ;
                    it.first = 13'(i_read_index);
                    it.in_range = ({4'd0, i_read_index} < 13'(r_count))
                                  && ({4'd0, i_read_index} < 13'(MAX_POINTS));
                end
                CMD_INIT: begin
                    o_item_valid = 1'b1;
                    n_count = '0; n_lx = i_pos_x; n_ly = i_pos_y;
                end
                default: o_item_valid = 1'b1;
            endcase
        end
        it.op_busy = (n_op != OP_IDLE);
        it.valid = n_valid;
        it.count = 10'(n_count);
    end

    assign o_item  = it;
    assign o_we    = take;
    assign o_waddr = r_count[IDX_W-1:0];
    assign o_wx    = r_sx;
    assign o_wy    = r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(64'd16777216); r_base <= '0; r_sect <= '0; r_magic <= '0;
            r_count <= '0; r_lx <= '0; r_ly <= '0; r_op <= OP_IDLE; r_sub <= SS_HDR;
            r_page <= '0; r_valid <= 1'b0; r_sq_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THR:   r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_BASE:  r_base <= i_cfg_data[ADDR_W-1:0];
                    CFG_SECT:  r_sect <= i_cfg_data[10:0];
                    default:   r_magic <= i_cfg_data[31:0];
                endcase
            end
            r_count <= n_count; r_lx <= n_lx; r_ly <= n_ly; r_op <= n_op;
            r_sub <= n_sub; r_page <= n_page; r_valid <= n_valid;
            r_sq_pend <= acc && (i_command == CMD_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sq <= $unsigned(dxx + dyy); r_sx <= i_pos_x; r_sy <= i_pos_y;
        end
    end
endmodule

### hdl/prfs_fifo.sv
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module prfs_fifo
    import prfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_mem[r_wp] <= i_item;
    end
endmodule

### hdl/prfs_back.sv
// ----------------------------------------------------------------------------
// Path recorder back end
// Turns queued items into result transactions: status results, point reads
// and the word stream of a page program.
// ----------------------------------------------------------------------------
module prfs_back
    import prfs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int IDX_W = $clog2(MAX_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic [IDX_W-1:0]  o_raddr,
    input  logic [POS_W-1:0]  i_rx,
    input  logic [POS_W-1:0]  i_ry,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [127:0]      o_data,
    output logic              o_last
);
    t_bk_state        r_st, n_st;
    t_item            r_it;
    logic [5:0]       r_j, n_j;
    logic             r_half, n_half;
    logic [POS_W-1:0] r_rx, r_ry;
    logic [IDX_W-1:0] r_ra, n_ra;
    logic             r_ovalid;
    logic [127:0]     r_odata, n_odata;
    logic             r_olast, n_olast;
    logic             load, capture, emit;

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_raddr = n_ra;
    assign emit    = !r_ovalid || i_ready;

    function automatic logic [127:0] pack(t_item it, logic [31:0] d,
                                          logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        return {1'b0, it.taken, y, x, it.count, it.valid, it.op_busy,
                d, it.len, it.addr, it.fcmd};
    endfunction

    always_comb begin
        n_st = r_st; n_j = r_j; n_half = r_half; n_ra = r_ra;
        n_odata = r_odata; n_olast = r_olast; load = 1'b0; capture = 1'b0;
        o_ready = 1'b0;
        case (r_st)
            BK_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    load = 1'b1;
                    n_ra = i_item.first[IDX_W-1:0];
                    n_j = '0; n_half = 1'b0;
                    case (i_item.kind)
                        K_READ: n_st = BK_READ;
                        K_PAGE: n_st = BK_READ;
                        default: n_st = BK_EMIT;
                    endcase
                end
            end
            BK_READ: begin
                capture = 1'b1;
                n_st = (r_it.kind == K_PAGE) ? BK_WORDS : BK_EMIT;
            end
            BK_EMIT: if (emit) begin
                n_odata = (r_it.kind == K_READ && r_it.in_range)
                          ? pack(r_it, r_it.data, r_rx, r_ry)
                          : pack(r_it, r_it.data, '0, '0);
                n_olast = 1'b1;
                n_st = BK_IDLE;
            end
            default: if (emit) begin
                n_odata = pack(r_it, r_half ? {{8{r_ry[POS_W-1]}}, r_ry}
                                            : {{8{r_rx[POS_W-1]}}, r_rx}, '0, '0);
                n_olast = r_half && (r_j + 1'b1 == r_it.chunk);
                n_half = ~r_half;
                if (r_half) begin
                    n_j = r_j + 1'b1;
                    n_ra = r_ra + 1'b1;
                    n_st = n_olast ? BK_IDLE : BK_READ;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if ((r_st == BK_EMIT || r_st == BK_WORDS) && emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_it <= i_item;
        if (capture) begin r_rx <= i_rx; r_ry <= i_ry; end
        r_j <= n_j; r_half <= n_half; r_ra <= n_ra;
        r_odata <= n_odata; r_olast <= n_olast;
    end
endmodule

### hdl/path_recorder_flash_saver_core.sv
// ----------------------------------------------------------------------------
// Path recorder flash saver core
// Records positions and streams flash program and erase commands.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel and results leave on m_axis; every
// command gives one result transaction except the page-program step of a
// save, which gives two words per stored point (x then y, sign-extended),
// with tlast set on the final result of each command.
// A sample is accepted and squared, then compared and stored in the front
// end; commands are accepted every cycle while the queue has room and no
// sample waits in the compare stage.
// The back end passes an ordinary result through its emit state, a point
// read through the registered store port (read, then emit), and each page
// program point through one store read and then an x word and a y word.
// Configuration writes use the cfg channel, which is always ready.
// Reset clears the count, the sequencer and the valid flag; the point store
// keeps its contents. When the receiver stalls, the output register holds
// its transaction, the queue fills, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
module path_recorder_flash_saver_core
    import prfs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: command[2:0], pos_x[26:3], pos_y[50:27],
    // flash_busy[51], read_index[60:52]
    input  logic [63:0]  s_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: flash_command[1:0], flash_address[24:2],
    // byte_length[33:25], data_word[65:34], flash_op_busy[66],
    // record_valid[67], point_count[77:68], read_x[101:78],
    // read_y[125:102], point_taken[126]
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int IDX_W = $clog2(MAX_POINTS);

    logic             f_we;
    logic [IDX_W-1:0] f_waddr, b_raddr;
    logic             q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    t_item            q_in, q_out;
    logic [POS_W-1:0] rx, ry, wx, wy;

    assign o_cfg_ready = 1'b1;

    // Sample positions are written from the front end's compare stage.
    prfs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_command(s_axis_tdata[2:0]), .i_pos_x(s_axis_tdata[26:3]),
        .i_pos_y(s_axis_tdata[50:27]), .i_flash_busy(s_axis_tdata[51]),
        .i_read_index(s_axis_tdata[60:52]),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_we(f_we), .o_waddr(f_waddr), .o_wx(wx), .o_wy(wy),
        .o_item_valid(q_in_valid), .i_item_ready(q_in_ready), .o_item(q_in)
    );

    prfs_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk, .i_we(f_we), .i_waddr(f_waddr), .i_wdata(wx),
        .i_raddr(b_raddr), .o_rdata(rx)
    );
    prfs_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk, .i_we(f_we), .i_waddr(f_waddr), .i_wdata(wy),
        .i_raddr(b_raddr), .o_rdata(ry)
    );

    prfs_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(q_in_valid), .o_ready(q_in_ready), .i_item(q_in),
        .o_valid(q_out_valid), .i_ready(q_out_ready), .o_item(q_out)
    );

    prfs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_out_valid), .o_ready(q_out_ready), .i_item(q_out),
        .o_raddr(b_raddr), .i_rx(rx), .i_ry(ry),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule

### hdl/prfs_checker.sv
// ----------------------------------------------------------------------------
// Path recorder port checker
// Checks result stream behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module prfs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("bad flash command");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[77:68] <= 10'd512 || m_axis_tdata[77] == 1'b0)
        else $error("point count out of range");
    a_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[1:0] == 2'd2)
        else $error("multi-word run outside page program");
endmodule

bind path_recorder_flash_saver_core prfs_checker u_prfs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

### verif/tb_path_recorder_flash_saver_core.sv
// ----------------------------------------------------------------------------
// Path recorder flash saver core testbench
// Drives commands and register writes into the core and predicts every result
// transaction, including the full erase and save sequences, in a scoreboard.
// ----------------------------------------------------------------------------
import prfs_pkg::*;

// One result transaction as the core should send it.
typedef struct {
    logic [1:0]  fcmd;
    logic [22:0] addr;
    logic [8:0]  len;
    logic [31:0] data;
    logic        last;
    logic        op_busy;
    logic        valid;
    logic [9:0]  count;
    logic [23:0] rx;
    logic [23:0] ry;
    logic        taken;
} flash_result_t;

// Predictor of the core plus the queue of results it still owes.
class path_scoreboard;
    // Register copies.
    logic [49:0] thr_sq;
    logic [22:0] base_addr;
    logic [10:0] sector;
    logic [31:0] magic;
    // Core state copies.
    logic [23:0] px_store [MAX_POINTS_DEF];
    logic [23:0] py_store [MAX_POINTS_DEF];
    int          count;
    logic [23:0] last_x;
    logic [23:0] last_y;
    t_op         op;
    t_sub        sub;
    int          page;
    logic        valid_flag;
    // Statistics and bookkeeping.
    flash_result_t pending_results[$];
    int errors, results_seen, points_taken, saves_done;

    function new();
        thr_sq = 50'd16777216;
        base_addr = '0;
        sector = '0;
        magic = '0;
        count = 0;
        last_x = '0;
        last_y = '0;
        op = OP_IDLE;
        sub = SS_HDR;
        page = 0;
        valid_flag = 1'b0;
        errors = 0;
        results_seen = 0;
        points_taken = 0;
        saves_done = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [63:0] value);
        case (idx)
            CFG_THR:   thr_sq = value[49:0];
            CFG_BASE:  base_addr = value[22:0];
            CFG_SECT:  sector = value[10:0];
            default:   magic = value[31:0];
        endcase
    endfunction

    function flash_result_t blank();
        flash_result_t r;
        r = '{default: '0};
        return r;
    endfunction

    function flash_result_t flash_word(logic [1:0] fc, logic [22:0] a, logic [8:0] l,
                                       logic [31:0] d);
        flash_result_t r;
        r = blank();
        r.fcmd = fc;
        r.addr = a;
        r.len = l;
        r.data = d;
        return r;
    endfunction

    // One flash tick: advances the running erase or save by a step.
    function void advance_sequence(logic busy, ref flash_result_t res[$]);
        int first, chunk;
        logic [22:0] pa;
        if (op == OP_ERASE) begin
            if (sub == SS_HDR) begin
                res.push_back(flash_word(FC_ERASE, {12'd0, sector}, 9'd0, 32'd0));
                sub = SS_HPOLL;
                return;
            end
            if (!busy) begin
                op = OP_IDLE;
                sub = SS_HDR;
            end
            res.push_back(blank());
            return;
        end
        if (op != OP_SAVE) begin
            res.push_back(blank());
            return;
        end
        case (sub)
            SS_HDR: begin
                res.push_back(flash_word(FC_PROG, base_addr + 23'd4, 9'd4, count));
                sub = SS_HPOLL;
            end
            SS_HPOLL: begin
                if (!busy) begin
                    sub = SS_PAGE;
                    page = 0;
                end
                res.push_back(blank());
            end
            SS_PAGE: begin
                first = page * POINTS_PER_PAGE;
                chunk = (count > first) ? count - first : 0;
                if (chunk > POINTS_PER_PAGE) chunk = POINTS_PER_PAGE;
                pa = base_addr + 23'd8 + 23'(page * PAGE_BYTES);
                sub = SS_PPOLL;
                // An empty store still costs one plain status result here.
                if (chunk == 0) res.push_back(blank());
                for (int j = 0; j < chunk; j++) begin
                    res.push_back(flash_word(FC_PROG, pa, 9'(chunk * 8),
                        {{8{px_store[first + j][23]}}, px_store[first + j]}));
                    res.push_back(flash_word(FC_PROG, pa, 9'(chunk * 8),
                        {{8{py_store[first + j][23]}}, py_store[first + j]}));
                end
            end
            SS_PPOLL: begin
                if (!busy) begin
                    page++;
                    sub = (page * POINTS_PER_PAGE < count) ? SS_PAGE : SS_MAGIC;
                end
                res.push_back(blank());
            end
            SS_MAGIC: begin
                res.push_back(flash_word(FC_PROG, base_addr, 9'd4, magic));
                sub = SS_MPOLL;
            end
            default: begin
                if (!busy) begin
                    op = OP_IDLE;
                    sub = SS_HDR;
                    valid_flag = 1'b1;
                    saves_done++;
                end
                res.push_back(blank());
            end
        endcase
    endfunction

    // Works out the results of one accepted command and queues them.
    function void note_command(logic [2:0] cmd, logic [23:0] px, logic [23:0] py,
                               logic busy, logic [8:0] idx);
        flash_result_t res[$];
        logic [23:0] rx, ry;
        logic taken;
        longint dx, dy;
        longint unsigned dist_sq;
        rx = '0;
        ry = '0;
        taken = 1'b0;
        case (cmd)
            CMD_SAMPLE: begin
                if (count < MAX_POINTS_DEF) begin
                    dx = longint'($signed(px)) - longint'($signed(last_x));
                    dy = longint'($signed(py)) - longint'($signed(last_y));
                    dist_sq = dx * dx + dy * dy;
                    if (dist_sq >= thr_sq) begin
                        px_store[count] = px;
                        py_store[count] = py;
                        count++;
                        last_x = px;
                        last_y = py;
                        taken = 1'b1;
                        points_taken++;
                    end
                end
                res.push_back(blank());
            end
            CMD_ERASE: begin
                if (op == OP_IDLE) begin
                    op = OP_ERASE;
                    sub = SS_HDR;
                end
                res.push_back(blank());
            end
            CMD_SAVE: begin
                if (op == OP_IDLE) begin
                    op = OP_SAVE;
                    sub = SS_HDR;
                    page = 0;
                end
                res.push_back(blank());
            end
            CMD_TICK: advance_sequence(busy, res);
            CMD_READ: begin
                if (idx < count) begin
                    rx = px_store[idx];
                    ry = py_store[idx];
                end
                res.push_back(blank());
            end
            CMD_INIT: begin
                count = 0;
                last_x = px;
                last_y = py;
                res.push_back(blank());
            end
            default: res.push_back(blank());
        endcase
        // Status fields reflect the state after the step, on every word.
        foreach (res[k]) begin
            res[k].last = (k == res.size() - 1);
            res[k].op_busy = (op != OP_IDLE);
            res[k].valid = valid_flag;
            res[k].count = 10'(count);
            res[k].rx = rx;
            res[k].ry = ry;
            res[k].taken = taken;
            pending_results.push_back(res[k]);
        end
    endfunction

    function void compare_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, exp_v, act_v);
        end
    endfunction

    function void check_result(logic [127:0] tdata, logic tlast);
        flash_result_t e;
        results_seen++;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, tdata);
            return;
        end
        e = pending_results.pop_front();
        compare_field("flash_command", e.fcmd, tdata[1:0]);
        compare_field("flash_address", e.addr, tdata[24:2]);
        compare_field("byte_length", e.len, tdata[33:25]);
        compare_field("data_word", e.data, tdata[65:34]);
        compare_field("last_of_run", e.last, tlast);
        compare_field("flash_op_busy", e.op_busy, tdata[66]);
        compare_field("record_valid", e.valid, tdata[67]);
        compare_field("point_count", e.count, tdata[77:68]);
        compare_field("read_x", e.rx, tdata[101:78]);
        compare_field("read_y", e.ry, tdata[125:102]);
        compare_field("point_taken", e.taken, tdata[126]);
    endfunction
endclass

module tb_path_recorder_flash_saver_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tlast;

    path_scoreboard sb;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int stall_cycles = 0;
    int commands_sent = 0;

    path_recorder_flash_saver_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // The receiver stalls at random; its ready changes only at clock edges.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // The watchdog ends a run in which no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Sends one command transaction; the sender may idle first. tvalid is only
    // lowered in idle cycles, so back-to-back commands keep it high.
    task automatic send_command(logic [2:0] cmd, logic [23:0] px, logic [23:0] py,
                                logic busy, logic [8:0] idx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'd0, idx, busy, py, px, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, px, py, busy, idx);
        commands_sent++;
    endtask

    // Lets the core drain so that a register can be written while it is idle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_register(idx, value);
        @(posedge i_clk);
    endtask

    // Random command with a mix leaning on samples and ticks so that saves
    // progress through all their pages.
    task automatic send_random_command();
        int r;
        logic [2:0] cmd;
        logic [23:0] px, py;
        logic [8:0] idx;
        r = $urandom_range(99);
        if (r < 36) cmd = CMD_SAMPLE;
        else if (r < 62) cmd = CMD_TICK;
        else if (r < 72) cmd = CMD_READ;
        else if (r < 79) cmd = CMD_SAVE;
        else if (r < 84) cmd = CMD_ERASE;
        else if (r < 88) cmd = CMD_INIT;
        else if (r < 91) cmd = 3'($urandom_range(6, 7));
        else cmd = CMD_SAMPLE;
        if ($urandom_range(1)) begin
            px = 24'($urandom);
            py = 24'($urandom);
        end else begin
            // Short hops around the last stored position exercise the distance threshold.
            px = sb.last_x + 24'($signed($urandom_range(0, 16383)) - 8192);
            py = sb.last_y + 24'($signed($urandom_range(0, 16383)) - 8192);
        end
        if ($urandom_range(1))
            idx = 9'($urandom_range(0, (sb.count + 2 > 511) ? 511 : sb.count + 2));
        else
            idx = 9'($urandom);
        send_command(cmd, px, py, 1'($urandom_range(1)), idx);
    endtask

    // Ticks until the running erase or save has finished.
    task automatic finish_sequence();
        while (sb.op != OP_IDLE)
            send_command(CMD_TICK, 24'($urandom), 24'($urandom),
                         ($urandom_range(99) < 30), 9'($urandom));
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with extreme register values.
        write_register(CFG_THR, 64'd0);
        write_register(CFG_BASE, 64'h7FFFFF);
        write_register(CFG_SECT, 64'd2047);
        write_register(CFG_MAGIC, 64'hFFFF_FFFF);
        send_command(CMD_INIT, 24'h000000, 24'h000000, 1'b0, 9'd0);
        // Save with no points, then the erase sequence with a refused request.
        send_command(CMD_SAVE, 24'h0, 24'h0, 1'b0, 9'd0);
        send_command(CMD_ERASE, 24'h0, 24'h0, 1'b0, 9'd0);
        finish_sequence();
        send_command(CMD_TICK, 24'h0, 24'h0, 1'b1, 9'd0);
        send_command(CMD_ERASE, 24'h0, 24'h0, 1'b0, 9'd0);
        send_command(CMD_SAVE, 24'h0, 24'h0, 1'b0, 9'd0);
        send_command(CMD_TICK, 24'h0, 24'h0, 1'b0, 9'd0);
        send_command(CMD_TICK, 24'h0, 24'h0, 1'b1, 9'd0);
        send_command(CMD_TICK, 24'h0, 24'h0, 1'b0, 9'd0);
        // Extreme positions, reads in and out of range, unused codes.
        send_command(CMD_SAMPLE, 24'h7FFFFF, 24'h800000, 1'b1, 9'd0);
        send_command(CMD_SAMPLE, 24'h800000, 24'h7FFFFF, 1'b0, 9'd0);
        send_command(CMD_SAMPLE, 24'hFFFFFF, 24'h000001, 1'b0, 9'd0);
        send_command(CMD_READ, 24'h0, 24'h0, 1'b0, 9'd1);
        send_command(CMD_READ, 24'h0, 24'h0, 1'b0, 9'd511);
        send_command(3'd6, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 9'd511);
        send_command(3'd7, 24'h0, 24'h0, 1'b0, 9'd0);
        send_command(CMD_SAVE, 24'h0, 24'h0, 1'b0, 9'd0);
        finish_sequence();
        wait_drained();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 58 : 0;
            dst_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 35 : 0;
            write_register(CFG_THR, (ph == 0) ? 64'd16777216 :
                                    (ph == 1) ? {14'd0, 50'h3_FFFF_FFFF_FFFF} :
                                                64'($urandom_range(0, 1 << 26)));
            write_register(CFG_BASE, 64'($urandom));
            write_register(CFG_SECT, 64'($urandom));
            write_register(CFG_MAGIC, 64'($urandom));
            repeat (10) send_random_command();
            // A well-formed save of whatever is stored, run to its end.
            send_command(CMD_SAVE, 24'h0, 24'h0, 1'b0, 9'd0);
            finish_sequence();
            wait_drained();
        end

        // Store just over one page of points and save both pages.
        write_register(CFG_THR, 64'd0);
        write_register(CFG_BASE, 64'h7FFF00);
        send_command(CMD_INIT, 24'($urandom), 24'($urandom), 1'b0, 9'd0);
        repeat (POINTS_PER_PAGE + 1)
            send_command(CMD_SAMPLE, 24'($urandom), 24'($urandom), 1'b0, 9'd0);
        send_command(CMD_READ, 24'h0, 24'h0, 1'b0, 9'd32);
        send_command(CMD_SAVE, 24'h0, 24'h0, 1'b0, 9'd0);
        finish_sequence();

        // Wait for the last results, then a little longer for stray ones.
        wait_drained();
        repeat (50) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d results; %0d points stored, %0d saves done.",
                 commands_sent, sb.results_seen, sb.points_taken, sb.saves_done);
        $display("Covered erase, empty and two-page saves, reads, init and unused codes.");
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
